// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge of clk, ignored while in reset
`define SPWM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, also active during reset
`define SPWM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/spwm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spwm_pkg
// Shared constants, register codes and the divider cell payload type.
// ----------------------------------------------------------------------------
package spwm_pkg;

    // sample and count widths
    localparam int SAMPLE_BITS = 10;
    localparam int FS          = (1 << SAMPLE_BITS) - 1;
    localparam int MAG_BITS    = 8;
    localparam int LED_BITS    = 16;
    localparam int FRAC_BITS   = 16;

    // divider datapath: remainder/divisor width, quotient bits = cell count
    localparam int DW     = 48;
    localparam int QW     = 24;
    localparam int TW     = 24;
    localparam int NCELLS = QW;

    // reciprocals for the constant divisions (exact over the operand ranges)
    localparam logic [25:0] RECIP_1023 = 26'd33587233;   // ceil(2^35 / 1023)
    localparam logic [24:0] RECIP_100  = 25'd21474837;   // ceil(2^31 / 100)

    // configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 8;

    localparam logic [CFG_IDX_W-1:0] REG_FREQ_MIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_MAX     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_MAX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STRENGTH_MIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STRENGTH_MAX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LED_DUTY     = 3'd5;

    // one item in flight through a divider cell
    typedef struct packed {
        logic          valid;
        logic [DW-1:0] rem;
        logic [DW-1:0] dsh;
        logic [QW-1:0] q;
        logic [TW-1:0] tag;
    } div_t;

    // load a division: divisor pre-shifted to the top quotient bit
    function automatic div_t div_load(logic v, logic [DW-1:0] num,
                                      logic [DW-1:0] den, logic [TW-1:0] tag);
        div_t d;
        d.valid = v;
        d.rem   = num;
        d.dsh   = den << (QW - 1);
        d.q     = '0;
        d.tag   = tag;
        return d;
    endfunction

    // floor(y / 1023) for y below 2^25
    function automatic logic [15:0] div1023(logic [24:0] y);
        logic [50:0] p;
        p = 51'(y) * 51'(RECIP_1023);
        return p[50:35];
    endfunction

    // floor(x / 100) for x below 2^24
    function automatic logic [17:0] div100(logic [23:0] x);
        logic [48:0] p;
        p = 49'(x) * 49'(RECIP_100);
        return p[48:31];
    endfunction

endpackage

// ===== rtl/core/spwm_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spwm_div_cell
// One restoring division step: resolves one quotient bit per item.
// ----------------------------------------------------------------------------
module spwm_div_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  spwm_pkg::div_t   din,
    output spwm_pkg::div_t   dout
);

    logic                    ge;
    spwm_pkg::div_t          step;
    logic                    valid_reg;
    logic [spwm_pkg::DW-1:0] rem_reg;
    logic [spwm_pkg::DW-1:0] dsh_reg;
    logic [spwm_pkg::QW-1:0] q_reg;
    logic [spwm_pkg::TW-1:0] tag_reg;

    // compare, subtract, shift the divisor down
    always_comb
    begin
        ge         = (din.rem >= din.dsh);
        step.valid = din.valid;
        step.rem   = ge ? (din.rem - din.dsh) : din.rem;
        step.dsh   = din.dsh >> 1;
        step.q     = {din.q[spwm_pkg::QW-2:0], ge};
        step.tag   = din.tag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= step.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= step.rem;
            dsh_reg <= step.dsh;
            q_reg   <= step.q;
            tag_reg <= step.tag;
        end
    end

    assign dout.valid = valid_reg;
    assign dout.rem   = rem_reg;
    assign dout.dsh   = dsh_reg;
    assign dout.q     = q_reg;
    assign dout.tag   = tag_reg;

endmodule

// ===== rtl/core/spwm_div_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spwm_div_chain
// Row of division cells, one quotient bit per cell, one item per cycle while en is high.
// ----------------------------------------------------------------------------
module spwm_div_chain (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  spwm_pkg::div_t din,
    output spwm_pkg::div_t dout
);

    spwm_pkg::div_t link [spwm_pkg::NCELLS+1];

    assign link[0] = din;

    // cells hand their item to the neighbor each enabled cycle
    for (genvar i = 0; i < spwm_pkg::NCELLS; i++)
    begin : g_cell
        spwm_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .din   (link[i]),
            .dout  (link[i+1])
        );
    end

    assign dout = link[spwm_pkg::NCELLS];

endmodule

// ===== rtl/core/strobe_pwm_period_calculator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strobe_pwm_period_calculator
// Maps three knob samples to magnet and LED timer period and compare counts.
// ----------------------------------------------------------------------------
// channel | direction | handshake        | payload
// in      | input     | in_valid/stall   | freq/shift/strength_sample
// out     | output    | out_valid/stall  | magnet_top/compare, led_top/compare
// cfg     | input     | cfg_we           | cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; the pipeline holds two mapping
// stages, a row of 24 divider cells, a product register and the output register.
// Each divider row resolves one quotient bit per cell.
// Reset clears valid bits only; config registers take their defaults.
// A stalled output holding a valid item freezes the whole pipeline and stalls the input.
module strobe_pwm_period_calculator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [spwm_pkg::SAMPLE_BITS-1:0]    freq_sample,
    input  logic [spwm_pkg::SAMPLE_BITS-1:0]    shift_sample,
    input  logic [spwm_pkg::SAMPLE_BITS-1:0]    strength_sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [spwm_pkg::MAG_BITS-1:0]       magnet_top,
    output logic [spwm_pkg::MAG_BITS-1:0]       magnet_compare,
    output logic [spwm_pkg::LED_BITS-1:0]       led_top,
    output logic [spwm_pkg::LED_BITS-1:0]       led_compare,
    input  logic                                cfg_we,
    input  logic [spwm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [spwm_pkg::CFG_W-1:0]          cfg_data
);

    `include "assert_macros.svh"

    localparam int DW = spwm_pkg::DW;
    localparam int SB = spwm_pkg::SAMPLE_BITS;
    localparam logic [SB-1:0] FS_S      = SB'(spwm_pkg::FS);
    localparam logic [24:0]   HALF_FS_Y = 25'(spwm_pkg::FS / 2);
    localparam logic [24:0]   ONE_HZ    = 25'd65536;
    localparam logic [DW-1:0] MAG_NUM   = DW'(64'd15625 << spwm_pkg::FRAC_BITS);
    localparam logic [DW-1:0] LED_NUM   = DW'(64'd250000 << spwm_pkg::FRAC_BITS);
    localparam logic [23:0]   PCT_HLF   = 24'd50;
    localparam logic [spwm_pkg::QW-1:0] MAG_MAX = spwm_pkg::QW'((1 << spwm_pkg::MAG_BITS) - 1);
    localparam logic [spwm_pkg::QW-1:0] LED_MAX = spwm_pkg::QW'((1 << spwm_pkg::LED_BITS) - 1);
    localparam logic [17:0]   MCMP_MAX  = 18'((1 << spwm_pkg::MAG_BITS) - 1);
    localparam logic [17:0]   LCMP_MAX  = 18'((1 << spwm_pkg::LED_BITS) - 1);

    // configuration registers
    logic [7:0] freq_min_reg;
    logic [7:0] freq_max_reg;
    logic [3:0] shift_max_reg;
    logic [6:0] strength_min_reg;
    logic [6:0] strength_max_reg;
    logic [6:0] led_duty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_min_reg     <= 8'd65;
            freq_max_reg     <= 8'd100;
            shift_max_reg    <= 4'd2;
            strength_min_reg <= 7'd5;
            strength_max_reg <= 7'd25;
            led_duty_reg     <= 7'd20;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                spwm_pkg::REG_FREQ_MIN:     freq_min_reg     <= cfg_data;
                spwm_pkg::REG_FREQ_MAX:     freq_max_reg     <= cfg_data;
                spwm_pkg::REG_SHIFT_MAX:    shift_max_reg    <= cfg_data[3:0];
                spwm_pkg::REG_STRENGTH_MIN: strength_min_reg <= cfg_data[6:0];
                spwm_pkg::REG_STRENGTH_MAX: strength_max_reg <= cfg_data[6:0];
                spwm_pkg::REG_LED_DUTY:     led_duty_reg     <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // pipeline advances unless a finished item is held at the output
    logic en;
    logic out_valid_reg;
    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    // linear knob mapping, numerators for division by full scale
    logic [18:0] pf;
    logic [13:0] ps;
    logic [17:0] pd;
    logic        s1_valid_reg;
    logic [18:0] pf_reg;
    logic [13:0] ps_reg;
    logic [17:0] pd_reg;

    always_comb
    begin
        pf = 19'(freq_min_reg * (FS_S - freq_sample)) + 19'(freq_max_reg * freq_sample);
        ps = 14'(shift_max_reg * shift_sample);
        pd = 18'(strength_max_reg * (FS_S - strength_sample))
           + 18'(strength_min_reg * strength_sample);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pf_reg <= pf;
            ps_reg <= ps;
            pd_reg <= pd;
        end
    end

    // Q16 divide by full scale: 65536*p = 1023*64*p + 64*p, so only the
    // small remainder term needs the reciprocal multiply
    logic [24:0] yf, ys, yd;
    logic [23:0] fmag_q, spos_q, duty_q;
    logic        s2_valid_reg;
    logic [23:0] fmag_reg, spos_reg, duty_reg;

    always_comb
    begin
        yf     = (25'(pf_reg) << 6) + HALF_FS_Y;
        ys     = (25'(ps_reg) << 7) + HALF_FS_Y;
        yd     = (25'(pd_reg) << 6) + HALF_FS_Y;
        fmag_q = (24'(pf_reg) << 6) + 24'(spwm_pkg::div1023(yf));
        spos_q = (24'(ps_reg) << 7) + 24'(spwm_pkg::div1023(ys));
        duty_q = (24'(pd_reg) << 6) + 24'(spwm_pkg::div1023(yd));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fmag_reg <= fmag_q;
            spos_reg <= spos_q;
            duty_reg <= duty_q;
        end
    end

    // LED frequency with shift, both frequencies clamped to 1 Hz
    logic [24:0] f_sum, f_neg, f_led, f_mag;
    spwm_pkg::div_t l2m, l2l, c2m, c2l;

    always_comb
    begin
        f_sum = 25'(fmag_reg) + 25'(spos_reg);
        f_neg = 25'({shift_max_reg, 16'h0000});
        f_led = (f_sum < f_neg + ONE_HZ) ? ONE_HZ : (f_sum - f_neg);
        f_mag = (25'(fmag_reg) < ONE_HZ) ? ONE_HZ : 25'(fmag_reg);
        l2m = spwm_pkg::div_load(s2_valid_reg, MAG_NUM + DW'(f_mag >> 1), DW'(f_mag),
                                 duty_reg);
        l2l = spwm_pkg::div_load(s2_valid_reg, LED_NUM + DW'(f_led >> 1), DW'(f_led), '0);
    end

    spwm_div_chain u_mtop (.clk(clk), .rst_n(rst_n), .en(en), .din(l2m), .dout(c2m));
    spwm_div_chain u_ltop (.clk(clk), .rst_n(rst_n), .en(en), .din(l2l), .dout(c2l));

    // saturate periods, register duty products
    logic [spwm_pkg::MAG_BITS-1:0] mtop_sat;
    logic [spwm_pkg::LED_BITS-1:0] ltop_sat;
    logic                          prod_valid_reg;
    logic [31:0]                   pm_reg;
    logic [22:0]                   pl_reg;
    logic [spwm_pkg::MAG_BITS-1:0] mtop_reg;
    logic [spwm_pkg::LED_BITS-1:0] ltop_reg;

    assign mtop_sat = (c2m.q > MAG_MAX) ? MAG_MAX[spwm_pkg::MAG_BITS-1:0]
                                        : c2m.q[spwm_pkg::MAG_BITS-1:0];
    assign ltop_sat = (c2l.q > LED_MAX) ? LED_MAX[spwm_pkg::LED_BITS-1:0]
                                        : c2l.q[spwm_pkg::LED_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            prod_valid_reg <= c2m.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pm_reg   <= 32'(c2m.tag * mtop_sat);
            pl_reg   <= 23'(led_duty_reg * ltop_sat);
            mtop_reg <= mtop_sat;
            ltop_reg <= ltop_sat;
        end
    end

    // percent of period, rounded; the Q16 scale drops out before the divide
    logic [17:0] mcmp_q, lcmp_q;

    always_comb
    begin
        mcmp_q = spwm_pkg::div100(24'(pm_reg[31:16]) + PCT_HLF);
        lcmp_q = spwm_pkg::div100(24'(pl_reg) + PCT_HLF);
    end

    // output register
    logic [spwm_pkg::MAG_BITS-1:0] mtop_out_reg, mcmp_out_reg;
    logic [spwm_pkg::LED_BITS-1:0] ltop_out_reg, lcmp_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mtop_out_reg <= mtop_reg;
            ltop_out_reg <= ltop_reg;
            mcmp_out_reg <= (mcmp_q > MCMP_MAX) ? MCMP_MAX[spwm_pkg::MAG_BITS-1:0]
                                                : mcmp_q[spwm_pkg::MAG_BITS-1:0];
            lcmp_out_reg <= (lcmp_q > LCMP_MAX) ? LCMP_MAX[spwm_pkg::LED_BITS-1:0]
                                                : lcmp_q[spwm_pkg::LED_BITS-1:0];
        end
    end

    assign out_valid      = out_valid_reg;
    assign magnet_top     = mtop_out_reg;
    assign magnet_compare = mcmp_out_reg;
    assign led_top        = ltop_out_reg;
    assign led_compare    = lcmp_out_reg;

    // periods can never reach zero: frequencies are bounded above
    `SPWM_ASSERT(a_mtop_nonzero, out_valid |-> (magnet_top != '0), "magnet period zero")
    `SPWM_ASSERT(a_ltop_nonzero, out_valid |-> (led_top != '0), "LED period zero")
    // an item leaving the product stage always lands in the output register
    `SPWM_ASSERT(a_last_to_out, prod_valid_reg |=> out_valid, "item lost at output")

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strobe PWM period calculator testbench
// Drives knob sample items with bursty valid and a random output stall,
// predicts the four timer counts per item in fixed point and checks every
// result in order. Several register settings are visited, extremes included.
// ----------------------------------------------------------------------------

// Holds predicted timer counts and compares them with results in order
class timer_count_board;
    typedef struct packed {
        logic [7:0]  mag_top;
        logic [7:0]  mag_cmp;
        logic [15:0] led_top;
        logic [15:0] led_cmp;
    } counts_t;

    counts_t pending[$];
    int      errors;

    // registers
    logic [7:0] fmin, fmax;
    logic [3:0] smax_hz;
    logic [6:0] str_min, str_max, led_pct;

    function void set_defaults();
        fmin = 65; fmax = 100; smax_hz = 2;
        str_min = 5; str_max = 25; led_pct = 20;
    endfunction

    function void write_reg(logic [2:0] idx, logic [7:0] val);
        case (idx)
            spwm_pkg::REG_FREQ_MIN:     fmin = val;
            spwm_pkg::REG_FREQ_MAX:     fmax = val;
            spwm_pkg::REG_SHIFT_MAX:    smax_hz = val[3:0];
            spwm_pkg::REG_STRENGTH_MIN: str_min = val[6:0];
            spwm_pkg::REG_STRENGTH_MAX: str_max = val[6:0];
            spwm_pkg::REG_LED_DUTY:     led_pct = val[6:0];
            default: ;
        endcase
    endfunction

    function longint unsigned rdiv(longint unsigned n, longint unsigned d);
        return (n + d / 2) / d;
    endfunction

    function longint unsigned clip(longint unsigned v, longint unsigned m);
        return (v > m) ? m : v;
    endfunction

    // predict counts for one accepted sample set
    function void note_item(logic [9:0] a, logic [9:0] b, logic [9:0] c);
        longint unsigned fs, q, fmag, spos, sneg, duty, fled, mt, mc, lt, lc;
        counts_t r;
        fs = 1023; q = 65536;
        fmag = rdiv(q * (fmin * (fs - a) + fmax * a), fs);
        spos = rdiv(q * 2 * smax_hz * b, fs);
        sneg = smax_hz * q;
        duty = rdiv(q * (str_max * (fs - c) + str_min * c), fs);
        fled = fmag + spos;
        if (fled < sneg + q) fled = q;
        else fled -= sneg;
        if (fmag < q) fmag = q;
        mt = clip(rdiv(15625 * q, fmag), 255);
        mc = clip(rdiv(duty * mt, 100 * q), 255);
        lt = clip(rdiv(250000 * q, fled), 65535);
        lc = clip(rdiv(led_pct * lt, 100), 65535);
        r.mag_top = 8'(mt); r.mag_cmp = 8'(mc); r.led_top = 16'(lt); r.led_cmp = 16'(lc);
        pending.push_back(r);
    endfunction

    function void check_result(counts_t got);
        counts_t want;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", got);
            return;
        end
        want = pending.pop_front();
        if (got !== want) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: exp top/cmp %0d/%0d led %0d/%0d, got %0d/%0d led %0d/%0d",
                         want.mag_top, want.mag_cmp, want.led_top, want.led_cmp,
                         got.mag_top, got.mag_cmp, got.led_top, got.led_cmp);
        end
    endfunction
endclass

module testbench;

    localparam int LATENCY = 2 + 24 + 2;
    localparam int IDLE_LIMIT = 20000;

    logic clk = 0, rst_n = 0;
    logic in_valid = 0, in_stall;
    logic [spwm_pkg::SAMPLE_BITS-1:0] freq_sample = 0, shift_sample = 0, strength_sample = 0;
    logic out_valid, out_stall = 0;
    logic [spwm_pkg::MAG_BITS-1:0] magnet_top, magnet_compare;
    logic [spwm_pkg::LED_BITS-1:0] led_top, led_compare;
    logic cfg_we = 0;
    logic [spwm_pkg::CFG_IDX_W-1:0] cfg_index = 0;
    logic [spwm_pkg::CFG_W-1:0] cfg_data = 0;

    timer_count_board board;
    int  idle_cycles = 0;
    bit  hold_off = 0;
    bit  stall_random = 1;

    strobe_pwm_period_calculator dut (.*);

    always #4 clk = ~clk;

    // receiver stall pattern, with an optional long hold-off
    always @(posedge clk)
    begin
        if (hold_off) out_stall <= 1;
        else if (stall_random) out_stall <= ($urandom_range(0, 3) == 0);
        else out_stall <= 0;
    end

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result({magnet_top, magnet_compare, led_top, led_compare});
    end

    // watchdog on cycles with no accepted item or result
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[strobe_pwm_period_calculator] ERROR");
            $finish;
        end
    end

    // offer one item and wait until it is accepted
    task automatic send_samples(logic [9:0] a, logic [9:0] b, logic [9:0] c);
        in_valid <= 1;
        freq_sample <= a; shift_sample <= b; strength_sample <= c;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_item(a, b, c);
    endtask

    task automatic drop_valid();
        in_valid <= 0;
        @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
        board.write_reg(idx, val);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // random items in bursts with gaps
    task automatic random_burst_items(int count);
        int burst, gap, sent;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 20);
            for (int i = 0; i < burst && sent < count; i++) begin
                if ($urandom_range(0, 7) == 0)
                    send_samples($urandom_range(0, 1) ? 10'h3FF : 10'h000,
                                 $urandom_range(0, 1) ? 10'h3FF : 10'h000,
                                 10'($urandom));
                else
                    send_samples(10'($urandom), 10'($urandom), 10'($urandom));
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                drop_valid();
                repeat (gap - 1) @(posedge clk);
            end
        end
    endtask

    task automatic set_all(logic [7:0] f0, logic [7:0] f1, logic [7:0] s,
                           logic [7:0] p0, logic [7:0] p1, logic [7:0] d);
        write_reg(spwm_pkg::REG_FREQ_MIN, f0);
        write_reg(spwm_pkg::REG_FREQ_MAX, f1);
        write_reg(spwm_pkg::REG_SHIFT_MAX, s);
        write_reg(spwm_pkg::REG_STRENGTH_MIN, p0);
        write_reg(spwm_pkg::REG_STRENGTH_MAX, p1);
        write_reg(spwm_pkg::REG_LED_DUTY, d);
    endtask

    initial
    begin
        board = new();
        board.set_defaults();
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: field extremes and alternating-bit patterns at defaults
        send_samples(0, 0, 0);
        send_samples(10'h3FF, 10'h3FF, 10'h3FF);
        send_samples(0, 10'h3FF, 10'h3FF);
        send_samples(10'h3FF, 0, 0);
        send_samples(10'h2AA, 10'h155, 10'h200);
        send_samples(10'h155, 10'h2AA, 10'h1FF);
        drain();

        // zero limits: sub-1 Hz clamp on both frequencies, zero duties
        set_all(0, 0, 15, 0, 0, 0);
        send_samples(0, 0, 0);
        send_samples(10'h3FF, 10'h3FF, 10'h3FF);
        send_samples(10'h200, 10'h200, 10'h200);
        drain();

        // reversed limits, percent over one hundred, wide register data
        set_all(255, 1, 8'hF7, 127, 101, 8'hFF);
        write_reg(6, 8'h55);
        write_reg(7, 8'hAA);
        send_samples(0, 0, 0);
        send_samples(10'h3FF, 10'h3FF, 10'h3FF);
        send_samples(1, 10'h3FE, 10'h100);
        drain();

        // top extremes: fastest frequencies give the shortest periods
        set_all(255, 255, 0, 100, 100, 100);
        send_samples(0, 10'h3FF, 0);
        send_samples(10'h3FF, 0, 10'h3FF);
        drain();

        // random phases across settings
        set_all(65, 100, 2, 5, 25, 20);
        random_burst_items(300);
        drain();

        set_all(1, 255, 15, 0, 100, 100);
        random_burst_items(250);
        drain();

        // long receiver hold-off while items keep coming
        set_all(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(0, 127)),
                8'($urandom_range(0, 127)), 8'($urandom_range(0, 127)));
        fork
            random_burst_items(300);
            begin
                hold_off = 1;
                repeat (300) @(posedge clk);
                hold_off = 0;
            end
        join
        drain();

        // no idling on either side
        stall_random = 0;
        set_all(0, 60, 7, 100, 0, 50);
        for (int i = 0; i < 150; i++)
            send_samples(10'($urandom), 10'($urandom), 10'($urandom));
        drain();
        stall_random = 1;

        set_all(200, 10, 1, 30, 70, 101);
        random_burst_items(250);
        drain();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("[strobe_pwm_period_calculator] OK");
        else
            $display("[strobe_pwm_period_calculator] ERROR");
        $finish;
    end
endmodule
